FILE: rtl/evad_pkg.sv
// Shared types, constants and register indexes for the voice activity detector.
`default_nettype none
package evad_pkg;
  localparam int HistoryDepthDef = 64;
  localparam int MaxFrameDef     = 4096;

  localparam logic [2:0] RegFrameLength   = 3'd0;
  localparam logic [2:0] RegLongCount     = 3'd1;
  localparam logic [2:0] RegOnsetDelay    = 3'd2;
  localparam logic [2:0] RegSilenceFrames = 3'd3;
  localparam logic [2:0] RegStaticUpdate  = 3'd4;
  localparam logic [2:0] RegBgCoeff       = 3'd5;
  localparam logic [2:0] RegLowestPower   = 3'd6;
  localparam logic [2:0] RegInitialBg     = 3'd7;

  typedef enum logic [3:0] {
    StIdle, StClear, StDivSh, StHistRd, StHistWr, StDivLg, StDecide, StSmooth1,
    StSmooth2, StOut
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/evad_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module evad_divider
  import evad_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [17:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[31]} - {1'b0, dsr_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit and subtract when it fits
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) busy_d = 1'b0;
    end
  end

  // done is a one-cycle flag after the last step
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= busy_q && !req_i.start && cnt_q == 6'd31;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

FILE: rtl/energy_voice_activity_detector_top.sv
// Top level of the energy-based voice activity detector with hangover.
//
//  channel   | dir | tdata fields (low bit up)                         | handshake
//  s_axis    | in  | sample[15:0]                                       | tvalid/tready
//  m_axis    | out | short_energy, long_energy, background_level         | tvalid/tready
//            |     | (tuser: speech_detected, state_change)              |
//  cfg       | in  | index cfg_idx_i, data cfg_data_i                   | cfg_we_i
//
// A sample that does not end a frame leaves the detector idle, ready for the next one.
// A frame end stalls the input through the short-mean pass of the shared 32-step
// divider, history read, history write, the long-mean pass, decision, two smoothing
// steps and the output load.
// After reset, and after a long_frame_count write, the history memory is
// swept clear, one entry a cycle, with s_axis_tready low.
// A result waits in the output register; the next sample is taken meanwhile,
// but a frame end stalls until the held result has been taken.
`default_nettype none
module energy_voice_activity_detector_top
  import evad_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistoryDepthDef,
  parameter int MAX_FRAME     = MaxFrameDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // short_energy, long_energy, background_level
  output logic [1:0]       m_axis_tuser,   // speech_detected, state_change
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(MAX_FRAME + 1);

  // configuration
  logic [12:0] frame_len_q;
  logic [6:0]  long_cnt_q;
  logic [7:0]  onset_delay_q, silence_frames_q, static_upd_q;
  logic [8:0]  coeff_q;
  logic [15:0] lowest_q;

  // state
  state_e      state_q, state_d;
  logic [31:0] acc_q;
  logic [FW-1:0] scnt_q;
  logic [HW-1:0] hptr_q, clr_q;
  logic [31:0] hsum_q;
  logic [7:0]  onset_q, silence_q, upd_q;
  logic [4:0]  hang_len_q;
  logic [5:0]  hang_cnt_q;
  logic        cd_q, det_q, change_q;
  logic [1:0]  last_q;
  logic [16:0] bgm_q, bgs_q;
  logic [16:0] sh_q, lg_q, old_q;
  logic [31:0] prod_q;
  logic        out_v_q;
  logic [1:0]  out_user_q;
  logic [47:0] out_data_q;

  logic [16:0] history_mem [HISTORY_DEPTH];

  // effective settings
  logic [FW-1:0] flen;
  logic [HW:0]   cnt;
  logic [7:0]    upd;
  logic [8:0]    coeff;
  logic [16:0]   init_clamp;
  always_comb begin
    flen = (frame_len_q == 13'd0) ? FW'(1) :
           ({19'd0, frame_len_q} > 32'(MAX_FRAME)) ? FW'(MAX_FRAME) : FW'(frame_len_q);
    cnt  = (long_cnt_q == 7'd0) ? (HW+1)'(1) :
           ({25'd0, long_cnt_q} > 32'(HISTORY_DEPTH)) ? (HW+1)'(HISTORY_DEPTH)
                                                      : (HW+1)'(long_cnt_q);
    upd  = (static_upd_q == 8'd0) ? 8'd1 : static_upd_q;
    coeff = (coeff_q > 9'd256) ? 9'd256 : coeff_q;
    init_clamp = (cfg_data_i > 16'd32768) ? 17'd32768 : {1'b0, cfg_data_i};
  end

  logic [16:0] mag;
  assign mag = s_axis_tdata[15] ? (17'h10000 - {1'b0, s_axis_tdata}) : {1'b0, s_axis_tdata};

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  evad_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic frame_end;
  assign frame_end = ({1'b0, scnt_q} + (FW+1)'(1)) >= {1'b0, flen};
  assign s_axis_tready = (state_q == StIdle) && !(frame_end && out_v_q);
  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // decision combinational values
  logic [31:0] sh32, lg32, bs32;
  logic on_test, low_test, quiet_both;
  assign sh32 = {15'd0, sh_q};
  assign lg32 = {15'd0, lg_q};
  assign bs32 = {15'd0, bgs_q};
  assign on_test  = (sh32 * 5 > lg32 * 6) && (sh32 * 2 > bs32 * 3) && (lg32 * 2 > bs32 * 3);
  assign low_test = (sh32 * 10 < lg32 * 7) && (sh32 * 2 < bs32 * 3);
  assign quiet_both = (sh32 * 2 < bs32 * 3) && (lg32 * 2 < bs32 * 3);

  always_comb begin
    state_d = state_q;
    dreq.start = 1'b0;
    dreq.dividend = acc_q + {15'd0, mag};
    dreq.divisor = {{(17-FW){1'b0}}, flen};
    case (state_q)
      StIdle:   if (s_fire && frame_end) begin
        dreq.start = 1'b1;
        state_d = StDivSh;
      end
      StClear:  if (clr_q == HW'(HISTORY_DEPTH - 1)) state_d = StIdle;
      StDivSh:  if (drsp.done) state_d = StHistRd;
      StHistRd: state_d = StHistWr;
      StHistWr: begin
        dreq.start = 1'b1;
        dreq.dividend = hsum_q - {15'd0, old_q} + {15'd0, sh_q};
        dreq.divisor = {{(16-HW){1'b0}}, cnt};
        state_d = StDivLg;
      end
      StDivLg:  if (drsp.done) state_d = StDecide;
      StDecide: state_d = StSmooth1;
      StSmooth1: state_d = StSmooth2;
      StSmooth2: state_d = StOut;
      StOut:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
    if (cfg_we_i && cfg_idx_i == RegLongCount) state_d = StClear;
  end

  // decision step temporaries
  logic [7:0] on_n, sil_n;
  logic [5:0] hc_n;
  logic cd_n, det_n, ch_n, smooth_n;
  logic [1:0] last_n;
  always_comb begin
    on_n = onset_q; hc_n = hang_cnt_q; cd_n = cd_q; det_n = det_q;
    ch_n = 1'b0; last_n = last_q; sil_n = silence_q;
    if (on_test) begin
      if (lg_q > {1'b0, lowest_q}) begin
        if (on_n != 8'd255) on_n = on_n + 8'd1;
        if (on_n > onset_delay_q) begin
          ch_n = 1'b1; last_n = 2'd1; hc_n = {1'b0, hang_len_q};
          cd_n = 1'b0; sil_n = 8'd0; det_n = 1'b1;
        end
      end
    end else on_n = 8'd0;
    if (cd_n) begin
      if (hc_n == 6'd0) begin
        ch_n = 1'b1; last_n = 2'd2; cd_n = 1'b0; on_n = 8'd0; det_n = 1'b0;
      end else hc_n = hc_n - 6'd1;
    end
    if (low_test) begin
      if (hc_n == 6'd0) hc_n = {1'b0, hang_len_q};
      cd_n = 1'b1;
    end
    if (!ch_n) det_n = (last_n == 2'd1);
    if (!cd_n && quiet_both) begin
      det_n = 1'b0; last_n = 2'd2;
    end
    if (last_n == 2'd2 && sil_n != 8'd255) sil_n = sil_n + 8'd1;
    smooth_n = (last_n == 2'd2) && !cd_n && (sil_n > silence_frames_q);
  end

  logic smooth_q;
  logic [16:0] newbg;
  assign newbg = 17'((prod_q + 32'd128) >> 8);
  logic [7:0] upd_inc;
  assign upd_inc = (upd_q == 8'd255) ? upd_q : upd_q + 8'd1;

  always_ff @(posedge clk_i) begin
    if (state_q == StHistWr) history_mem[hptr_q] <= sh_q;
    if (state_q == StClear) history_mem[clr_q] <= '0;
    old_q <= history_mem[hptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= 13'd256; long_cnt_q <= 7'd8; onset_delay_q <= 8'd0;
      silence_frames_q <= 8'd10; static_upd_q <= 8'd10; coeff_q <= 9'd38;
      lowest_q <= 16'd164;
      state_q <= StClear; clr_q <= '0; acc_q <= '0; scnt_q <= '0;
      hptr_q <= '0; hsum_q <= '0; onset_q <= '0; silence_q <= '0; upd_q <= '0;
      hang_len_q <= 5'd5; hang_cnt_q <= '0; cd_q <= 1'b0; det_q <= 1'b0;
      change_q <= 1'b0; last_q <= 2'd0; bgm_q <= 17'd492; bgs_q <= 17'd492;
      out_v_q <= 1'b0; smooth_q <= 1'b0;
      sh_q <= '0; lg_q <= '0; prod_q <= '0; out_user_q <= '0; out_data_q <= '0;
    end else begin
      state_q <= state_d;
      if (m_axis_tready) out_v_q <= 1'b0;
      if (state_q == StClear) clr_q <= clr_q + HW'(1);
      if (s_fire) begin
        if (frame_end) begin
          acc_q <= '0; scnt_q <= '0;
        end else begin
          acc_q <= acc_q + {15'd0, mag}; scnt_q <= scnt_q + FW'(1);
        end
      end
      if (state_q == StDivSh && drsp.done) begin
        sh_q <= drsp.quotient[16:0];
        if ({{(32-HW){1'b0}}, hptr_q} >= 32'(cnt)) hptr_q <= '0;
      end
      if (state_q == StHistWr) begin
        hsum_q <= hsum_q - {15'd0, old_q} + {15'd0, sh_q};
        hptr_q <= (({1'b0, hptr_q} + (HW+1)'(1)) >= cnt) ? '0 : hptr_q + HW'(1);
      end
      if (state_q == StDivLg && drsp.done) lg_q <= drsp.quotient[16:0];
      if (state_q == StDecide) begin
        onset_q <= on_n; hang_cnt_q <= hc_n; cd_q <= cd_n; det_q <= det_n;
        change_q <= ch_n; last_q <= last_n; silence_q <= sil_n; smooth_q <= smooth_n;
        prod_q <= {23'd0, 9'd256 - coeff} * {15'd0, bgm_q};
      end
      if (state_q == StSmooth1) prod_q <= prod_q + {23'd0, coeff} * {15'd0, sh_q};
      if (state_q == StSmooth2) begin
        if (smooth_q) begin
          bgm_q <= newbg;
          upd_q <= upd_inc;
          if (upd_inc >= upd) begin
            bgs_q <= newbg; upd_q <= '0;
            if (newbg >= 17'd164) hang_len_q <= 5'd10;
            if (newbg >= 17'd328) hang_len_q <= 5'd15;
            if (newbg >= 17'd492) hang_len_q <= 5'd20;
            if (newbg <= 17'd16)  hang_len_q <= 5'd5;
          end
        end else begin
          bgm_q <= bgs_q; upd_q <= '0;
        end
      end
      if (state_q == StOut) begin
        out_v_q <= 1'b1;
        out_user_q <= {change_q, det_q};
        out_data_q <= {bgs_q[15:0], lg_q[15:0], sh_q[15:0]};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFrameLength:   frame_len_q <= cfg_data_i[12:0];
          RegLongCount: begin
            long_cnt_q <= cfg_data_i[6:0]; hptr_q <= '0; hsum_q <= '0; clr_q <= '0;
          end
          RegOnsetDelay:    onset_delay_q <= cfg_data_i[7:0];
          RegSilenceFrames: silence_frames_q <= cfg_data_i[7:0];
          RegStaticUpdate:  static_upd_q <= cfg_data_i[7:0];
          RegBgCoeff:       coeff_q <= cfg_data_i[8:0];
          RegLowestPower:   lowest_q <= cfg_data_i;
          RegInitialBg: begin
            bgm_q <= init_clamp; bgs_q <= init_clamp;
          end
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire
